FILE: design/cbd_pkg.sv
// shared types and constants for the chunked body decoder
// no dependencies; imported by cbd_line_feed and chunked_body_decoder_core
package cbd_pkg;

    // decoder phase
    typedef enum logic [2:0] {
        PH_LINE     = 3'd0,
        PH_LINE_CR  = 3'd1,
        PH_DATA     = 3'd2,
        PH_TRAIL_CR = 3'd3,
        PH_TRAIL_LF = 3'd4,
        PH_HALT     = 3'd5
    } phase_t;

    // status codes carried with a status word
    typedef enum logic [2:0] {
        ST_DONE       = 3'd0,
        ST_NO_LINE    = 3'd1,
        ST_BAD_SIZE   = 3'd2,
        ST_INCOMPLETE = 3'd3,
        ST_NO_CRLF    = 3'd4
    } status_t;

    // flags of the size line being parsed
    typedef struct packed {
        logic digits_seen;
        logic digits_ended;
        logic size_bad;
    } line_flags_t;

    // hex digit decode result
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_digit_t;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // decode one ascii hex digit, either case
    function automatic hex_digit_t hex_decode(input logic [7:0] c);
        hex_digit_t r;
        r.valid = 1'b1;
        r.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r.value = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r.value = 4'(c - 8'h37);
        end
        else
        begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: design/cbd_line_feed.sv
// size line character feed: folds one byte into the chunk size being parsed
// depends on cbd_pkg (line_flags_t, hex_decode)
module cbd_line_feed
    import cbd_pkg::*;
#(
    parameter int SIZE_WIDTH = 32
)
(
    input  logic [7:0]            ch,
    input  line_flags_t           flags_in,
    input  logic [SIZE_WIDTH-1:0] size_in,
    output line_flags_t           flags_out,
    output logic [SIZE_WIDTH-1:0] size_out
);

    hex_digit_t digit;

    assign digit = hex_decode(ch);

    // leading digits only; a non-hex byte ends the digit run
    always_comb
    begin
        flags_out = flags_in;
        size_out  = size_in;
        if (!flags_in.digits_ended)
        begin
            if (!digit.valid)
            begin
                flags_out.digits_ended = 1'b1;
            end
            else
            begin
                flags_out.digits_seen = 1'b1;
                if (!flags_in.size_bad)
                begin
                    // overflow when the top nibble is already in use
                    if (size_in[SIZE_WIDTH-1 -: 4] != 4'd0)
                    begin
                        flags_out.size_bad = 1'b1;
                    end
                    else
                    begin
                        size_out = {size_in[SIZE_WIDTH-5:0], digit.value};
                    end
                end
            end
        end
    end

endmodule

FILE: design/chunked_body_decoder_core.sv
// chunked body decoder: one input byte per clock, result held in an output register
// registered: an accepted byte's payload or status word is in the output register in the cycle after the byte
// throughput: one byte per cycle, set by the single state update per accepted byte
// s_tready drops only while the output register holds a word that is not taken
// reset (rst_n low, asynchronous) returns to the start of a size line, output empty
// depends on cbd_pkg and cbd_line_feed
module chunked_body_decoder_core
    import cbd_pkg::*;
#(
    parameter int SIZE_WIDTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // body_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] payload_byte
    output logic [3:0] m_tuser    // [0] is_status, [3:1] end_code
);

    phase_t                phase_reg, phase_next;
    line_flags_t           flags_reg, flags_next;
    logic [SIZE_WIDTH-1:0] chunk_reg, chunk_next;
    logic [SIZE_WIDTH-1:0] left_reg, left_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [7:0]            m_tdata_reg, m_tdata_next;
    logic [3:0]            m_tuser_reg, m_tuser_next;

    line_flags_t           feed_flags;
    logic [SIZE_WIDTH-1:0] feed_size;

    logic                  accept;
    logic                  restart;
    logic                  res_valid;
    logic                  res_status;
    status_t               res_code;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // size line digit folding for the current byte
    cbd_line_feed #(
        .SIZE_WIDTH (SIZE_WIDTH)
    ) u_feed (
        .ch        (s_tdata),
        .flags_in  (flags_reg),
        .size_in   (chunk_reg),
        .flags_out (feed_flags),
        .size_out  (feed_size)
    );

    // result of the current byte
    always_comb
    begin
        res_valid  = 1'b0;
        res_status = 1'b0;
        res_code   = ST_DONE;
        restart    = 1'b0;
        unique case (phase_reg)
            PH_LINE:
            begin
                if (s_tlast)
                begin
                    res_valid = 1'b1; res_status = 1'b1; res_code = ST_NO_LINE;
                    restart   = 1'b1;
                end
            end
            PH_LINE_CR:
            begin
                if (s_tdata == CHAR_LF)
                begin
                    if (!flags_reg.digits_seen || flags_reg.size_bad)
                    begin
                        res_valid = 1'b1; res_status = 1'b1; res_code = ST_BAD_SIZE;
                        restart   = s_tlast;
                    end
                    else if (s_tlast)
                    begin
                        res_valid = 1'b1; res_status = 1'b1; res_code = ST_INCOMPLETE;
                        restart   = 1'b1;
                    end
                end
                else if (s_tlast)
                begin
                    res_valid = 1'b1; res_status = 1'b1; res_code = ST_NO_LINE;
                    restart   = 1'b1;
                end
            end
            PH_DATA:
            begin
                res_valid = 1'b1;
                if (s_tlast)
                begin
                    res_status = 1'b1; res_code = ST_INCOMPLETE;
                    restart    = 1'b1;
                end
            end
            PH_TRAIL_CR:
            begin
                if (s_tlast)
                begin
                    res_valid = 1'b1; res_status = 1'b1; res_code = ST_INCOMPLETE;
                    restart   = 1'b1;
                end
                else if (s_tdata != CHAR_CR)
                begin
                    res_valid = 1'b1; res_status = 1'b1; res_code = ST_NO_CRLF;
                end
            end
            PH_TRAIL_LF:
            begin
                if (s_tdata != CHAR_LF)
                begin
                    res_valid = 1'b1; res_status = 1'b1; res_code = ST_NO_CRLF;
                    restart   = s_tlast;
                end
                else if (chunk_reg == '0)
                begin
                    res_valid = 1'b1; res_status = 1'b1; res_code = ST_DONE;
                    restart   = s_tlast;
                end
                else
                begin
                    // end of a nonzero chunk starts the next size line
                    if (s_tlast)
                    begin
                        res_valid = 1'b1; res_status = 1'b1; res_code = ST_NO_LINE;
                    end
                    restart = 1'b1;
                end
            end
            PH_HALT:
            begin
                restart = s_tlast;
            end
            default:
            begin
                restart = 1'b1;
            end
        endcase
    end

    // next decoder state
    always_comb
    begin
        phase_next = phase_reg;
        flags_next = flags_reg;
        chunk_next = chunk_reg;
        left_next  = left_reg;
        if (restart)
        begin
            phase_next = PH_LINE;
            flags_next = '0;
            chunk_next = '0;
            left_next  = '0;
        end
        else if (res_status)
        begin
            phase_next = PH_HALT;
        end
        else
        begin
            unique case (phase_reg)
                PH_LINE:
                begin
                    if (s_tdata == CHAR_CR)
                    begin
                        phase_next = PH_LINE_CR;
                    end
                    else
                    begin
                        flags_next = feed_flags;
                        chunk_next = feed_size;
                    end
                end
                PH_LINE_CR:
                begin
                    if (s_tdata == CHAR_LF)
                    begin
                        if (chunk_reg == '0)
                        begin
                            phase_next = PH_TRAIL_CR;
                        end
                        else
                        begin
                            left_next  = chunk_reg;
                            phase_next = PH_DATA;
                        end
                    end
                    else
                    begin
                        // a lone cr is a non-hex line character
                        flags_next.digits_ended = 1'b1;
                        phase_next = (s_tdata == CHAR_CR) ? PH_LINE_CR : PH_LINE;
                    end
                end
                PH_DATA:
                begin
                    left_next = left_reg - SIZE_WIDTH'(1);
                    if (left_reg == SIZE_WIDTH'(1))
                    begin
                        phase_next = PH_TRAIL_CR;
                    end
                end
                PH_TRAIL_CR:
                begin
                    phase_next = PH_TRAIL_LF;
                end
                PH_TRAIL_LF:
                begin
                    phase_next = PH_TRAIL_LF;
                end
                PH_HALT:
                begin
                    phase_next = PH_HALT;
                end
                default:
                begin
                    phase_next = PH_LINE;
                end
            endcase
        end
    end

    // output register load
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (s_tready)
        begin
            m_tvalid_next = accept && res_valid;
            m_tdata_next  = res_status ? 8'd0 : s_tdata;
            m_tuser_next  = {res_code, res_status};
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_LINE;
            flags_reg    <= '0;
            chunk_reg    <= '0;
            left_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
            if (accept)
            begin
                phase_reg <= phase_next;
                flags_reg <= flags_next;
                chunk_reg <= chunk_next;
                left_reg  <= left_next;
            end
        end
    end

    // output word registers
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

endmodule
